@@ rtl/dgh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgh_pkg
// Shared types, constants and tables for the dual receiver heading pairer.
// ----------------------------------------------------------------------------
package dgh_pkg;

  localparam int DEF_QUEUE_DEPTH = 5;

  localparam int CFG_DW = 26;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_MATCH_WINDOW = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_STARTUP_HOLD = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HEADING_OFS  = 2'd2;

  localparam logic [9:0]  RST_MATCH_WINDOW = 10'd20;
  localparam logic [25:0] RST_STARTUP_HOLD = 26'd5000000;
  localparam logic [15:0] RST_HEADING_OFS  = 16'd0;

  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [18:0] PI_Q13      = 19'sd25736;
  localparam logic signed [18:0] TWO_PI_Q13  = 19'sd51472;
  localparam logic [4:0]         CORDIC_LAST = 5'd16;

  localparam logic signed [63:0] NORM_LIMIT = 64'sh0400_0000_0000_0000;

  typedef struct packed {
    logic [3:0]         receiver_number;
    logic [27:0]        utc_milli;
    logic signed [39:0] east_mm;
    logic signed [39:0] north_mm;
    logic [52:0]        host_time_us;
  } in_t;

  typedef struct packed {
    logic               heading_valid;
    logic signed [15:0] heading;
    logic [3:0]         heading_receiver;
    logic [52:0]        heading_time_us;
  } out_t;

  typedef struct packed {
    logic [1:0]         rx;
    logic [27:0]        utc;
    logic signed [39:0] east;
    logic signed [39:0] north;
    logic [52:0]        host_time;
  } fix_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_START, S_RDI, S_CHKI, S_RDJ, S_CHKJ,
    S_NORM, S_ITER, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic admit;
    logic start_i;
    logic dec_i;
    logic start_j;
    logic dec_j;
    logic load_xy;
    logic norm_shift;
    logic rotate;
    logic iter;
    logic fin_hit;
    logic set_none;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic fill_zero;
    logic a_rx1;
    logic j_match;
    logic i_zero;
    logic j_zero;
    logic same_time;
    logic norm_done;
    logic iter_last;
    logic out_busy;
  } sts_t;

  function automatic logic signed [20:0] atan_q16(input logic [4:0] idx);
    logic signed [20:0] v;
    case (idx)
      5'd0:  v = 21'sd51472;
      5'd1:  v = 21'sd30385;
      5'd2:  v = 21'sd16055;
      5'd3:  v = 21'sd8150;
      5'd4:  v = 21'sd4091;
      5'd5:  v = 21'sd2047;
      5'd6:  v = 21'sd1024;
      5'd7:  v = 21'sd512;
      5'd8:  v = 21'sd256;
      5'd9:  v = 21'sd128;
      5'd10: v = 21'sd64;
      5'd11: v = 21'sd32;
      5'd12: v = 21'sd16;
      5'd13: v = 21'sd8;
      5'd14: v = 21'sd4;
      5'd15: v = 21'sd2;
      5'd16: v = 21'sd1;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/dgh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgh_ctrl
// Sequencer: admit a fix, walk the queue for a pair, run the arctangent.
// ----------------------------------------------------------------------------
module dgh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dgh_pkg::sts_t sts,
  output dgh_pkg::cmd_t cmd
);
  import dgh_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = sts.drop ? S_OUT : S_START;
      S_START: state_nxt = sts.fill_zero ? S_OUT : S_RDI;
      S_RDI:   state_nxt = S_CHKI;
      S_CHKI: begin
        if (sts.a_rx1) state_nxt = S_RDJ;
        else if (sts.i_zero) state_nxt = S_OUT;
        else state_nxt = S_RDI;
      end
      S_RDJ:   state_nxt = S_CHKJ;
      S_CHKJ: begin
        if (sts.j_match) state_nxt = sts.same_time ? S_OUT : S_NORM;
        else if (!sts.j_zero) state_nxt = S_RDJ;
        else if (sts.i_zero) state_nxt = S_OUT;
        else state_nxt = S_RDI;
      end
      S_NORM:  if (sts.norm_done) state_nxt = S_ITER;
      S_ITER:  if (sts.iter_last) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_LOAD: begin
        cmd.admit    = 1'b1;
        cmd.set_none = sts.drop;
      end
      S_START: begin
        cmd.set_none = sts.fill_zero;
        cmd.start_i  = !sts.fill_zero;
      end
      S_RDI: ;
      S_CHKI: begin
        cmd.start_j  = sts.a_rx1;
        cmd.set_none = !sts.a_rx1 && sts.i_zero;
        cmd.dec_i    = !sts.a_rx1 && !sts.i_zero;
      end
      S_RDJ: ;
      S_CHKJ: begin
        if (sts.j_match) begin
          cmd.set_none = sts.same_time;
          cmd.load_xy  = !sts.same_time;
        end else if (!sts.j_zero) begin
          cmd.dec_j = 1'b1;
        end else if (sts.i_zero) begin
          cmd.set_none = 1'b1;
        end else begin
          cmd.dec_i = 1'b1;
        end
      end
      S_NORM: begin
        cmd.norm_shift = !sts.norm_done;
        cmd.rotate     = sts.norm_done;
      end
      S_ITER:  cmd.iter    = 1'b1;
      S_FIN:   cmd.fin_hit = 1'b1;
      S_OUT:   cmd.emit    = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

@@ rtl/dgh_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgh_dp
// Datapath: config registers, fix queue memory, pair search compare,
// normalizer, CORDIC vectoring unit and the result register.
// ----------------------------------------------------------------------------
module dgh_dp #(
  parameter int QUEUE_DEPTH = dgh_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dgh_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [dgh_pkg::CFG_DW-1:0]  cfg_data,
  input  dgh_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dgh_pkg::out_t               out_data,
  input  dgh_pkg::cmd_t               cmd,
  output dgh_pkg::sts_t               sts
);
  import dgh_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

  // configuration
  logic [9:0]         win_r;
  logic [25:0]        hold_r;
  logic signed [15:0] ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= RST_MATCH_WINDOW;
      hold_r <= RST_STARTUP_HOLD;
      ofs_r  <= RST_HEADING_OFS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATCH_WINDOW: win_r  <= cfg_data[9:0];
        CFG_STARTUP_HOLD: hold_r <= cfg_data[25:0];
        CFG_HEADING_OFS:  ofs_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input latch and startup hold
  in_t         fix_r;
  logic        seen_r;
  logic [52:0] first_r;
  logic [52:0] first_eff;
  logic        drop;

  always_ff @(posedge clk) begin
    if (cmd.latch) fix_r <= in_data;
  end

  assign first_eff = seen_r ? first_r : fix_r.host_time_us;
  assign drop = (fix_r.host_time_us < first_eff) ||
                ((fix_r.host_time_us - first_eff) < 53'(hold_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      first_r <= '0;
    end else if (cmd.admit && !seen_r) begin
      seen_r  <= 1'b1;
      first_r <= fix_r.host_time_us;
    end
  end

  // circular queue
  fix_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [PW-1:0] i_r, j_r;
  fix_t          a_q, b_q;
  logic          push;
  logic [PW-1:0] wr_addr;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [PW:0] idx);
    logic [PW:0] s;
    s = {1'b0, h} + idx;
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[PW-1:0];
  endfunction

  assign push = cmd.admit && !drop &&
                (fix_r.receiver_number == 4'd1 || fix_r.receiver_number == 4'd2);
  assign wr_addr = (fill_r == FULL) ? head_r : phys(head_r, (PW + 1)'(fill_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (push) begin
      if (fill_r == FULL) begin
        head_r <= (head_r == LAST_P) ? '0 : head_r + 1'b1;
      end else begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_addr] <= '{rx: fix_r.receiver_number[1:0], utc: fix_r.utc_milli,
                        east: fix_r.east_mm, north: fix_r.north_mm,
                        host_time: fix_r.host_time_us};
    end
    a_q <= mem[phys(head_r, {1'b0, i_r})];
    b_q <= mem[phys(head_r, {1'b0, j_r})];
  end

  always_ff @(posedge clk) begin
    if (cmd.start_i) i_r <= PW'(fill_r - 1'b1);
    else if (cmd.dec_i) i_r <= i_r - 1'b1;
    if (cmd.start_j) j_r <= PW'(fill_r - 1'b1);
    else if (cmd.dec_j) j_r <= j_r - 1'b1;
  end

  logic signed [28:0] udiff;
  logic [28:0]        umag;
  logic [52:0]        last_r;

  assign udiff = $signed({1'b0, b_q.utc}) - $signed({1'b0, a_q.utc});
  assign umag  = udiff[28] ? 29'(-udiff) : 29'(udiff);

  // arctangent
  logic signed [63:0] x_r, y_r;
  logic signed [20:0] z_r;
  logic [4:0]         k_r;
  logic               zero_r;
  logic signed [63:0] sx, sy;
  logic               x_small, y_small;

  assign sx = x_r >>> k_r;
  assign sy = y_r >>> k_r;
  assign x_small = (x_r < NORM_LIMIT) && (x_r > -NORM_LIMIT);
  assign y_small = (y_r < NORM_LIMIT) && (y_r > -NORM_LIMIT);

  always_ff @(posedge clk) begin
    if (cmd.load_xy) begin
      x_r    <= 64'(a_q.east - b_q.east);
      y_r    <= 64'(a_q.north - b_q.north);
      zero_r <= (a_q.east == b_q.east) && (a_q.north == b_q.north);
    end else if (cmd.norm_shift) begin
      x_r <= x_r <<< 1;
      y_r <= y_r <<< 1;
    end else if (cmd.rotate) begin
      k_r <= '0;
      if (x_r < 0) begin
        z_r <= (y_r >= 0) ? PI_Q16 : -PI_Q16;
        x_r <= -x_r;
        y_r <= -y_r;
      end else begin
        z_r <= '0;
      end
    end else if (cmd.iter) begin
      k_r <= k_r + 1'b1;
      if (y_r > 0) begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + atan_q16(k_r);
      end else begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - atan_q16(k_r);
      end
    end
  end

  // round, add offset, wrap
  logic signed [20:0] zr;
  logic signed [18:0] ang, h0, h1;

  assign zr  = z_r + 21'sd4;
  assign ang = zero_r ? 19'sd0 : 19'(zr >>> 3);
  assign h0  = ang + 19'(ofs_r);
  always_comb begin
    if (h0 > PI_Q13) h1 = h0 - TWO_PI_Q13;
    else if (h0 < -PI_Q13) h1 = h0 + TWO_PI_Q13;
    else h1 = h0;
  end

  // result and output register
  logic               res_valid_r;
  logic signed [15:0] res_heading_r;
  logic [3:0]         res_rx_r;
  logic [52:0]        res_time_r;
  logic               out_valid_r;
  out_t               out_r;

  always_ff @(posedge clk) begin
    if (cmd.set_none) begin
      res_valid_r   <= 1'b0;
      res_heading_r <= '0;
      res_rx_r      <= '0;
      res_time_r    <= '0;
    end else begin
      if (cmd.load_xy) begin
        res_rx_r   <= 4'(a_q.rx);
        res_time_r <= a_q.host_time;
      end
      if (cmd.fin_hit) begin
        res_valid_r   <= 1'b1;
        res_heading_r <= h1[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_r      <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (res_valid_r) last_r <= res_time_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= '{heading_valid: res_valid_r, heading: res_heading_r,
                 heading_receiver: res_rx_r, heading_time_us: res_time_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts           = '0;
    sts.drop      = drop;
    sts.fill_zero = (fill_r == '0);
    sts.a_rx1     = (a_q.rx == 2'd1);
    sts.j_match   = (b_q.rx == 2'd2) && (umag < 29'(win_r));
    sts.i_zero    = (i_r == '0);
    sts.j_zero    = (j_r == '0);
    sts.same_time = (a_q.host_time == last_r);
    sts.norm_done = zero_r || !(x_small && y_small);
    sts.iter_last = (k_r == CORDIC_LAST);
    sts.out_busy  = out_valid_r && !out_ready;
  end

endmodule

@@ rtl/dual_gps_heading_pairer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_gps_heading_pairer
// Pairs receiver-1 and receiver-2 position fixes into a heading angle.
// ----------------------------------------------------------------------------
// One fix is worked at a time and every accepted fix yields exactly one
// result (heading_valid low when no new heading). A fix dropped by the
// startup hold goes straight to the output; otherwise the pair search visits
// queue entries, and on a match with a new host time the block runs one-bit
// normalizing shifts, the quadrant pre-rotation, the 17-step CORDIC and the
// final rounding. A result waiting in the output register stalls the next
// fix only at its final step.
module dual_gps_heading_pairer #(
  parameter int QUEUE_DEPTH = dgh_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dgh_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dgh_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [dgh_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [dgh_pkg::CFG_DW-1:0]  cfg_data
);
  import dgh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dgh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dgh_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("fix accepted while another is in flight");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.heading_valid |->
      out_data.heading == 16'sd0 && out_data.heading_receiver == 4'd0 &&
      out_data.heading_time_us == 53'd0)
    else $error("result without heading carries nonzero fields");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.heading_valid |->
      out_data.heading <= 16'sd25736 && out_data.heading >= -16'sd25736 &&
      out_data.heading_receiver == 4'd1)
    else $error("heading out of range or wrong receiver");

endmodule
